@@ design/u8cd_pkg.sv @@
// ----------------------------------------------------------------------------
// u8cd_pkg
// Shared types and constants for the UTF-8 code point decoder.
// ----------------------------------------------------------------------------
package u8cd_pkg;

    localparam int unsigned CpW = 21;

    // Byte class masks and match values
    localparam logic [7:0] AsciiMask  = 8'h80;
    localparam logic [7:0] Lead2Mask  = 8'he0;
    localparam logic [7:0] Lead2Val   = 8'hc0;
    localparam logic [7:0] Lead3Mask  = 8'hf0;
    localparam logic [7:0] Lead3Val   = 8'he0;
    localparam logic [7:0] Lead4Mask  = 8'hf8;
    localparam logic [7:0] Lead4Val   = 8'hf0;
    localparam logic [7:0] ContMask   = 8'hc0;
    localparam logic [7:0] ContVal    = 8'h80;

    // Payload masks
    localparam logic [7:0] Pay2Mask   = 8'h1f;
    localparam logic [7:0] Pay3Mask   = 8'h0f;
    localparam logic [7:0] Pay4Mask   = 8'h07;
    localparam logic [7:0] ContPayMask = 8'h3f;

    localparam logic [CpW-1:0] Replacement = 21'h00fffd;

    // Continuation bytes still needed after a lead byte
    localparam logic [1:0] Need2 = 2'd1;
    localparam logic [1:0] Need3 = 2'd2;
    localparam logic [1:0] Need4 = 2'd3;

    typedef struct packed {
        logic [7:0] byte_in;
        logic [1:0] bytes_after;
    } t_byte_item;

    typedef struct packed {
        logic [CpW-1:0] code_point;
        logic           replaced;
    } t_cp_item;

    typedef struct packed {
        logic [CpW-1:0] partial_value;
        logic [1:0]     bytes_pending;
        logic           dropping_rest;
    } t_dec_state;

    // Result of one decode step
    typedef struct packed {
        logic     emit;
        t_cp_item item;
    } t_step_res;

endpackage

@@ design/u8cd_stream_if.sv @@
// ----------------------------------------------------------------------------
// u8cd_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface u8cd_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ design/u8cd_step.sv @@
// ----------------------------------------------------------------------------
// u8cd_step
// Combinational decode of one byte against the current decoder state.
// ----------------------------------------------------------------------------
module u8cd_step (
    input  u8cd_pkg::t_byte_item i_item,
    input  u8cd_pkg::t_dec_state i_state,
    output u8cd_pkg::t_dec_state o_state,
    output u8cd_pkg::t_step_res  o_res
);

    logic       last;
    logic [7:0] b;
    logic [1:0] need;
    logic [7:0] lead_pay;
    logic       lead_ok;
    logic [1:0] pend_dec;
    logic [u8cd_pkg::CpW-1:0] shifted;

    assign b    = i_item.byte_in;
    assign last = (i_item.bytes_after == 2'd0);

    // Lead byte classification
    always_comb begin
        lead_ok  = 1'b1;
        need     = u8cd_pkg::Need2;
        lead_pay = b & u8cd_pkg::Pay2Mask;
        if ((b & u8cd_pkg::Lead2Mask) == u8cd_pkg::Lead2Val) begin
            need     = u8cd_pkg::Need2;
            lead_pay = b & u8cd_pkg::Pay2Mask;
        end else if ((b & u8cd_pkg::Lead3Mask) == u8cd_pkg::Lead3Val) begin
            need     = u8cd_pkg::Need3;
            lead_pay = b & u8cd_pkg::Pay3Mask;
        end else if ((b & u8cd_pkg::Lead4Mask) == u8cd_pkg::Lead4Val) begin
            need     = u8cd_pkg::Need4;
            lead_pay = b & u8cd_pkg::Pay4Mask;
        end else begin
            lead_ok  = 1'b0;
        end
    end

    assign shifted  = {i_state.partial_value[u8cd_pkg::CpW-7:0],
                       b[5:0] & u8cd_pkg::ContPayMask[5:0]};
    assign pend_dec = i_state.bytes_pending - 2'd1;

    // Next state and result
    always_comb begin
        o_state                = i_state;
        o_res.emit             = 1'b0;
        o_res.item.code_point  = u8cd_pkg::Replacement;
        o_res.item.replaced    = 1'b1;
        if (i_state.dropping_rest) begin
            // rest of a short string is discarded
        end else if (i_state.bytes_pending == 2'd0) begin
            if ((b & u8cd_pkg::AsciiMask) == 8'h00) begin
                o_res.emit            = 1'b1;
                o_res.item.code_point = {{(u8cd_pkg::CpW-8){1'b0}}, b};
                o_res.item.replaced   = 1'b0;
            end else if (!lead_ok) begin
                o_res.emit = 1'b1;
            end else if (i_item.bytes_after < need) begin
                // short string: flag it and swallow what is left
                o_res.emit            = 1'b1;
                o_state.partial_value = '0;
                o_state.bytes_pending = 2'd0;
                o_state.dropping_rest = !last;
            end else begin
                o_state.partial_value = {{(u8cd_pkg::CpW-8){1'b0}}, lead_pay};
                o_state.bytes_pending = need;
            end
        end else if ((b & u8cd_pkg::ContMask) != u8cd_pkg::ContVal) begin
            // broken sequence
            o_res.emit            = 1'b1;
            o_state.partial_value = '0;
            o_state.bytes_pending = 2'd0;
        end else begin
            o_state.partial_value = shifted;
            o_state.bytes_pending = pend_dec;
            if (pend_dec == 2'd0) begin
                o_res.emit            = 1'b1;
                o_res.item.code_point = shifted;
                o_res.item.replaced   = 1'b0;
                o_state.partial_value = '0;
            end else if (last) begin
                // sequence cut off by the string end
                o_res.emit = 1'b1;
            end
        end
        // string end clears everything
        if (last) begin
            o_state.partial_value = '0;
            o_state.bytes_pending = 2'd0;
            o_state.dropping_rest = 1'b0;
        end
    end

endmodule

@@ design/utf8_codepoint_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder
// Streaming UTF-8 decoder: one byte in per transfer, one code point out per
// completed character.
// ----------------------------------------------------------------------------
// Takes one byte per clock while the result side does not stall: a byte is
// registered on input, decoded combinationally against the sequence state,
// and the code point lands in the result register, from which it transfers
// out. The state update (partial value shift plus pending count) sets the
// rate of one byte per cycle. Lead bytes that open a sequence and bytes
// dropped after a short string give no result. Errors give U+FFFD with
// replaced set. Backpressure from the result side stalls the input register,
// which can still take one byte while a finished result waits.
module utf8_codepoint_decoder (
    input  logic i_clk,
    input  logic i_rst_n,
    u8cd_stream_if.sink   i_in,
    u8cd_stream_if.source o_out
);

    logic                  r_in_valid;
    u8cd_pkg::t_byte_item  r_in_item;
    u8cd_pkg::t_dec_state  r_state;
    u8cd_pkg::t_dec_state  n_state;
    u8cd_pkg::t_step_res   step_res;
    logic                  r_out_valid;
    u8cd_pkg::t_cp_item    r_out_item;
    logic                  advance;

    // Decode stage moves when the result register is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_in_item <= i_in.payload;
        end
    end

    u8cd_step u_step (
        .i_item  (r_in_item),
        .i_state (r_state),
        .o_state (n_state),
        .o_res   (step_res)
    );

    // Sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step_res.emit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && step_res.emit) begin
            r_out_item <= step_res.item;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_item;

endmodule

@@ tb/tb_utf8_codepoint_decoder.sv @@
// ----------------------------------------------------------------------------
// tb_utf8_codepoint_decoder
// Self-checking bench for the streaming UTF-8 decoder: byte strings go in on
// the input stream, and each code point that comes out is checked against a
// behavioural decoder kept in step with every accepted byte.
// ----------------------------------------------------------------------------
module tb_utf8_codepoint_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0] t_bytes [$];
    typedef logic [u8cd_pkg::CpW-1:0] t_cp_val;

    logic clk;
    logic rst_n;

    u8cd_stream_if #(.t_payload(u8cd_pkg::t_byte_item)) in_if ();
    u8cd_stream_if #(.t_payload(u8cd_pkg::t_cp_item))   out_if ();

    utf8_codepoint_decoder u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Expected code points, oldest first
    u8cd_pkg::t_cp_item cp_expect [$];

    // Behavioural decoder state
    t_cp_val        cp_acc;
    logic [1:0]     cont_left;
    logic           skip_to_end;

    int n_sent;
    int n_mismatch;
    int burst_left;
    bit sender_steady;

    // Clock and reset
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Decode one accepted byte; updates the shadow state
    function automatic void decode_byte(input logic [7:0] b, input logic [1:0] after,
                                        output bit has_cp, output u8cd_pkg::t_cp_item cp);
        logic       last;
        logic       bad_lead;
        logic [1:0] need;
        logic [7:0] pay;
        last     = (after == 2'd0);
        has_cp   = 1'b0;
        cp       = '0;
        bad_lead = 1'b0;
        need     = '0;
        pay      = '0;
        if (skip_to_end) begin
            // rest of a short string is swallowed
        end else if (cont_left == 2'd0) begin
            if ((b & u8cd_pkg::AsciiMask) == 8'h00) begin
                has_cp = 1'b1;
                cp     = '{code_point: t_cp_val'(b), replaced: 1'b0};
            end else begin
                if ((b & u8cd_pkg::Lead2Mask) == u8cd_pkg::Lead2Val) begin
                    need = u8cd_pkg::Need2;
                    pay  = b & u8cd_pkg::Pay2Mask;
                end else if ((b & u8cd_pkg::Lead3Mask) == u8cd_pkg::Lead3Val) begin
                    need = u8cd_pkg::Need3;
                    pay  = b & u8cd_pkg::Pay3Mask;
                end else if ((b & u8cd_pkg::Lead4Mask) == u8cd_pkg::Lead4Val) begin
                    need = u8cd_pkg::Need4;
                    pay  = b & u8cd_pkg::Pay4Mask;
                end else begin
                    bad_lead = 1'b1;
                end
                if (bad_lead) begin
                    has_cp = 1'b1;
                    cp     = '{code_point: u8cd_pkg::Replacement, replaced: 1'b1};
                end else if (after < need) begin
                    // not enough bytes left in the string for this character
                    has_cp      = 1'b1;
                    cp          = '{code_point: u8cd_pkg::Replacement, replaced: 1'b1};
                    cp_acc      = '0;
                    cont_left   = '0;
                    skip_to_end = !last;
                end else begin
                    cp_acc    = t_cp_val'(pay);
                    cont_left = need;
                end
            end
        end else if ((b & u8cd_pkg::ContMask) != u8cd_pkg::ContVal) begin
            // sequence broken by a non-continuation byte, which is consumed
            has_cp    = 1'b1;
            cp        = '{code_point: u8cd_pkg::Replacement, replaced: 1'b1};
            cp_acc    = '0;
            cont_left = '0;
        end else begin
            cp_acc    = {cp_acc[u8cd_pkg::CpW-7:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
                has_cp = 1'b1;
                cp     = '{code_point: cp_acc, replaced: 1'b0};
                cp_acc = '0;
            end else if (last) begin
                has_cp = 1'b1;
                cp     = '{code_point: u8cd_pkg::Replacement, replaced: 1'b1};
            end
        end
        if (last) begin
            cp_acc      = '0;
            cont_left   = '0;
            skip_to_end = 1'b0;
        end
    endfunction

    // Send one byte; bursts of random length separated by random gaps unless the sender is steady
    task automatic push_byte(input logic [7:0] b, input logic [1:0] after);
        bit                 has_cp;
        u8cd_pkg::t_cp_item cp;
        if (burst_left == 0) begin
            if (!sender_steady) begin
                in_if.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_if.valid   <= 1'b1;
        in_if.payload <= '{byte_in: b, bytes_after: after};
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        decode_byte(b, after, has_cp, cp);
        if (has_cp) cp_expect = {cp_expect, cp};
        n_sent++;
    endtask

    // Send a string with bytes_after worked out from its length
    task automatic send_text(input t_bytes txt);
        int rem;
        for (int i = 0; i < txt.size(); i++) begin
            rem = txt.size() - 1 - i;
            push_byte(txt[i], (rem > 3) ? 2'd3 : 2'(rem));
        end
    endtask

    // Append one character of len bytes (lead and continuation forms, random payload, overlong possible)
    task automatic add_char(ref t_bytes txt, input int len);
        case (len)
            1: txt = {txt, 8'($urandom_range(0, 127))};
            2: txt = {txt, 8'hc0 | 8'($urandom_range(0, 31))};
            3: txt = {txt, 8'he0 | 8'($urandom_range(0, 15))};
            default: txt = {txt, 8'hf0 | 8'($urandom_range(0, 7))};
        endcase
        for (int i = 1; i < len; i++) txt = {txt, 8'h80 | 8'($urandom_range(0, 63))};
    endtask

    task automatic make_text(ref t_bytes txt);
        int n_chars;
        txt = {};
        n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
        repeat (n_chars) add_char(txt, $urandom_range(1, 4));
    endtask

    // Let the pipeline empty out before going on
    task automatic wait_drain();
        in_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (cp_expect.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed_cases();
        // ASCII extremes and a two-byte character
        send_text('{8'h00, 8'h7f, 8'hc2, 8'ha9});
        // three- and four-byte characters
        send_text('{8'he2, 8'h82, 8'hac, 8'hf0, 8'h9f, 8'h98, 8'h80});
        // largest code point, then an overlong form that passes unchecked
        send_text('{8'hf7, 8'hbf, 8'hbf, 8'hbf, 8'hc0, 8'h80});
        // bad lead bytes
        send_text('{8'h80, 8'hf8, 8'hff});
        // lead with too few bytes left: rest of string dropped
        send_text('{8'he2, 8'h82});
        // sequence broken by ASCII, which is consumed
        send_text('{8'he2, 8'h41, 8'h42});
        // sequence still open at string end (inconsistent bytes_after)
        push_byte(8'he2, 2'd2);
        push_byte(8'h82, 2'd0);
    endtask

    task automatic test_wellformed_text(input int upto);
        t_bytes txt;
        int     n_txt;
        n_txt = 0;
        while (n_sent < upto) begin
            if (n_txt % 40 == 0) sender_steady = ($urandom_range(0, 3) == 0);
            make_text(txt);
            send_text(txt);
            n_txt++;
        end
        sender_steady = 1'b0;
    endtask

    task automatic test_corrupted_text(input int upto);
        t_bytes txt;
        int     pos;
        while (n_sent < upto) begin
            make_text(txt);
            if ($urandom_range(0, 2) == 0) begin
                pos = $urandom_range(0, txt.size() - 1);
                case ($urandom_range(0, 2))
                    0: txt.insert(pos, 8'($urandom));
                    1: if (txt.size() > 1) txt.delete(pos);
                    default: txt[pos] = 8'($urandom);
                endcase
            end
            send_text(txt);
        end
    endtask

    task automatic test_noise_items(input int upto);
        while (n_sent < upto) push_byte(8'($urandom), 2'($urandom_range(0, 3)));
        // close whatever string is open
        push_byte(8'($urandom_range(0, 127)), 2'd0);
    endtask

    task automatic test_drain_pause();
        t_bytes txt;
        repeat (5) begin
            make_text(txt);
            send_text(txt);
        end
        // open a sequence, hold off until all results are out, then finish it
        push_byte(8'he3, 2'd2);
        wait_drain();
        push_byte(8'h81, 2'd1);
        push_byte(8'h82, 2'd0);
        wait_drain();
    endtask

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------

    function automatic void report_bad(input string what, input u8cd_pkg::t_cp_item want,
                                       input u8cd_pkg::t_cp_item got);
        n_mismatch++;
        if (n_mismatch <= 10)
            $display("%0t: %s: expected cp=%06h rep=%0b, got cp=%06h rep=%0b", $realtime,
                     what, want.code_point, want.replaced, got.code_point, got.replaced);
    endfunction

    always @(posedge clk) begin : chk_cp
        u8cd_pkg::t_cp_item want;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (cp_expect.size() == 0) begin
                report_bad("unexpected code point", '0, out_if.payload);
            end else begin
                want = cp_expect.pop_front();
                if (out_if.payload.code_point !== want.code_point ||
                    out_if.payload.replaced !== want.replaced)
                    report_bad("code point mismatch", want, out_if.payload);
            end
        end
    end

    // Receiver back-pressure: rotating 8-bit pattern per run, some runs open
    initial begin : rx_stall
        logic [7:0] pat;
        int         run;
        out_if.ready <= 1'b0;
        forever begin
            pat = 8'($urandom);
            run = $urandom_range(8, 64);
            if ($urandom_range(0, 3) == 0) pat = 8'hff;
            else if ($urandom_range(0, 7) == 0) pat = 8'h01;
            for (int k = 0; k < run; k++) begin
                @(posedge clk);
                out_if.ready <= pat[k % 8];
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        in_if.valid   <= 1'b0;
        in_if.payload <= '0;
        cp_acc        = '0;
        cont_left     = '0;
        skip_to_end   = 1'b0;
        n_sent        = 0;
        n_mismatch    = 0;
        burst_left    = 0;
        sender_steady = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);

        test_directed_cases();
        test_wellformed_text(900);
        test_drain_pause();
        test_corrupted_text(1600);
        test_noise_items(1950);

        // wait for the last transfers to come out
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (cp_expect.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (n_mismatch == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/u8cd_pkg.sv
design/u8cd_stream_if.sv
design/u8cd_step.sv
design/utf8_codepoint_decoder.sv
tb/tb_utf8_codepoint_decoder.sv
